>>> rtl/wscr_pkg.sv
// ----------------------------------------------------------------------------
// Sweep column renderer package
// Sequencer states, register indices, input codes and fixed-point constants
// shared by the renderer core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wscr_pkg;

  // Field widths fixed by the interface.
  localparam int COLUMN_W   = 7;
  localparam int PIXELS_W   = 64;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 15;

  // Internal arithmetic widths.
  localparam int BASE_W = 24;   // baseline accumulator, signed Q4.20
  localparam int DIFF_W = 25;   // sample minus baseline, signed Q5.20
  localparam int MULB_W = 13;   // unsigned 12-bit weight or 8-bit gain, zero extended
  localparam int PROD_W = DIFF_W + MULB_W;
  localparam int ROWT_W = PROD_W + 1;
  localparam int ROW_W  = 6;

  // Configuration register indices.
  localparam logic [CFG_INDEX_W-1:0] REG_PLOT_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LEVEL    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_SLOPE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_GAIN       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLLING_GAIN     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_SAMPLES   = 3'd6;

  // Input item kinds and plot modes.
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;
  localparam logic MODE_ROLLING = 1'b0;
  localparam logic MODE_SWEEP   = 1'b1;

  // Register reset values.
  localparam logic        PLOT_MODE_RST        = MODE_SWEEP;
  localparam logic [11:0] SMOOTHING_WEIGHT_RST = 12'd41;
  localparam logic [14:0] TRIGGER_LEVEL_RST    = 15'd819;
  localparam logic [14:0] TRIGGER_SLOPE_RST    = 15'd205;
  localparam logic [7:0]  SWEEP_GAIN_RST       = 8'd30;
  localparam logic [7:0]  ROLLING_GAIN_RST     = 8'd20;
  localparam logic [7:0]  SETTLE_SAMPLES_RST   = 8'd125;

  // Row constants.
  localparam logic [ROW_W-1:0] ROLLING_ROW_INIT = 6'd48;
  localparam logic [ROW_W-1:0] SWEEP_ROW_INIT   = 6'd32;
  localparam logic [ROW_W-1:0] ROLLING_ROW_MIN  = 6'd32;
  localparam logic [ROW_W-1:0] ROW_MAX          = 6'd63;
  localparam logic [ROW_W-1:0] ROW_MIN          = 6'd0;

  // Row centres and floor in the scale of the product register.
  localparam logic signed [ROWT_W-1:0] ROLLING_MID   = 39'sd196608;   // 48 << 12
  localparam logic signed [ROWT_W-1:0] ROLLING_FLOOR = 39'sd131072;   // 32 << 12
  localparam logic signed [ROWT_W-1:0] SWEEP_MID     = 39'sd33554432; // 32 << 20

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROLL_MUL,
    S_ROLL_ROW,
    S_BASE_MUL,
    S_BASE_UPD,
    S_TRIG,
    S_SWEEP_MUL,
    S_SWEEP_ROW,
    S_DRAW,
    S_EMIT0,
    S_EMIT1,
    S_EMIT2
  } state_t;

endpackage

>>> rtl/waveform_sweep_column_renderer_core.sv
// ----------------------------------------------------------------------------
// Waveform sweep column renderer core
// Turns signed Q4.12 samples into column writes for a COLUMNS by 64 display,
// either as a rolling plot in the lower half or as a triggered full-screen
// sweep with a settle phase, an IIR baseline and a rising-edge trigger. One
// item is handled at a time by a small sequencer around a single shared
// 25 by 13 bit multiplier, whose product is registered before use. A restart
// item, or a sample consumed by the settle phase, is taken in the idle state
// without leaving it. A sweep sample held back by the trigger returns to idle
// from the trigger state. A drawn sample ends in three column writes, each held
// while the result side stalls, before the next item can be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waveform_sweep_column_renderer_core #(
  parameter int COLUMNS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input items
  input  logic                                 feed_valid,
  output logic                                 feed_stall,
  input  logic                                 kind,
  input  logic signed [wscr_pkg::SAMPLE_W-1:0] sample,
  // Result items
  output logic                                 draw_valid,
  input  logic                                 draw_stall,
  output logic [wscr_pkg::COLUMN_W-1:0]        column,
  output logic [wscr_pkg::PIXELS_W-1:0]        pixels,
  output logic                                 whole_column,
  output logic                                 last,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wscr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wscr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PTR_W = $clog2(COLUMNS);

  // Configuration registers
  logic        plot_mode;
  logic [11:0] smoothing_weight;
  logic [14:0] trigger_level;
  logic [14:0] trigger_slope;
  logic [7:0]  sweep_gain;
  logic [7:0]  rolling_gain;
  logic [7:0]  settle_samples;

  // Control state
  wscr_pkg::state_t state, state_next;
  logic [PTR_W-1:0]                  column_pointer;
  logic [wscr_pkg::ROW_W-1:0]        rolling_last_row;
  logic [wscr_pkg::ROW_W-1:0]        sweep_last_row;
  logic signed [wscr_pkg::BASE_W-1:0] baseline;
  logic signed [wscr_pkg::SAMPLE_W-1:0] previous_sample;
  logic                              awaiting_trigger;
  logic [7:0]                        settle_counter;

  // Working registers
  logic signed [wscr_pkg::SAMPLE_W-1:0] sample_reg;
  logic signed [wscr_pkg::PROD_W-1:0]   prod;
  logic signed [wscr_pkg::DIFF_W-1:0]   n_reg;
  logic [wscr_pkg::ROW_W-1:0]           seg_old;
  logic [wscr_pkg::ROW_W-1:0]           seg_new;
  logic [wscr_pkg::PIXELS_W-1:0]        pixels_reg;
  logic [PTR_W-1:0]                     col_reg;
  logic                                 whole_reg;

  // Combinational datapath
  logic                                 feed_take;
  logic                                 settling;
  logic signed [wscr_pkg::DIFF_W-1:0]   v20;
  logic signed [wscr_pkg::DIFF_W-1:0]   base_diff;
  logic signed [wscr_pkg::DIFF_W-1:0]   mul_a;
  logic signed [wscr_pkg::MULB_W-1:0]   mul_b;
  logic signed [wscr_pkg::PROD_W-1:0]   prod_next;
  logic signed [wscr_pkg::PROD_W-1:0]   prod_shift;
  logic signed [wscr_pkg::SAMPLE_W:0]   sample_rise;
  logic                                 trig_pass;
  logic                                 proceed;
  logic signed [wscr_pkg::ROWT_W-1:0]   prod_ext;
  logic signed [wscr_pkg::ROWT_W-1:0]   roll_t;
  logic signed [wscr_pkg::ROWT_W-1:0]   sweep_t;
  logic [wscr_pkg::ROW_W-1:0]           roll_row;
  logic [wscr_pkg::ROW_W-1:0]           sweep_row;
  logic [wscr_pkg::ROW_W-1:0]           seg_lo;
  logic [wscr_pkg::ROW_W-1:0]           seg_hi;
  logic [wscr_pkg::PIXELS_W-1:0]        seg_mask;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] sum;
    sum = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
    if (sum == (PTR_W+1)'(COLUMNS)) begin
      sum = '0;
    end
    return sum[PTR_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plot_mode        <= wscr_pkg::PLOT_MODE_RST;
      smoothing_weight <= wscr_pkg::SMOOTHING_WEIGHT_RST;
      trigger_level    <= wscr_pkg::TRIGGER_LEVEL_RST;
      trigger_slope    <= wscr_pkg::TRIGGER_SLOPE_RST;
      sweep_gain       <= wscr_pkg::SWEEP_GAIN_RST;
      rolling_gain     <= wscr_pkg::ROLLING_GAIN_RST;
      settle_samples   <= wscr_pkg::SETTLE_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wscr_pkg::REG_PLOT_MODE:        plot_mode        <= cfg_data[0];
        wscr_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[11:0];
        wscr_pkg::REG_TRIGGER_LEVEL:    trigger_level    <= cfg_data[14:0];
        wscr_pkg::REG_TRIGGER_SLOPE:    trigger_slope    <= cfg_data[14:0];
        wscr_pkg::REG_SWEEP_GAIN:       sweep_gain       <= cfg_data[7:0];
        wscr_pkg::REG_ROLLING_GAIN:     rolling_gain     <= cfg_data[7:0];
        wscr_pkg::REG_SETTLE_SAMPLES:   settle_samples   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  assign feed_take = feed_valid && !feed_stall;
  assign settling  = settle_counter < settle_samples;

  assign v20       = $signed({sample_reg[wscr_pkg::SAMPLE_W-1], sample_reg, 8'b0});
  assign base_diff = v20 - $signed({baseline[wscr_pkg::BASE_W-1], baseline});

  assign prod_next  = mul_a * mul_b;
  assign prod_shift = prod >>> 12;

  assign sample_rise = $signed({sample_reg[wscr_pkg::SAMPLE_W-1], sample_reg})
                     - $signed({previous_sample[wscr_pkg::SAMPLE_W-1], previous_sample});
  assign trig_pass = (base_diff > $signed({2'b00, trigger_level, 8'b0}))
                  && (sample_rise > $signed({2'b00, trigger_slope}));
  assign proceed   = !awaiting_trigger || trig_pass;

  assign prod_ext = $signed({prod[wscr_pkg::PROD_W-1], prod});
  assign roll_t   = wscr_pkg::ROLLING_MID - prod_ext;
  assign sweep_t  = wscr_pkg::SWEEP_MID - prod_ext;

  always_comb begin
    // Below row 32 the rolling plot sits on its floor; above row 63 it clips.
    if (roll_t < wscr_pkg::ROLLING_FLOOR) begin
      roll_row = wscr_pkg::ROLLING_ROW_MIN;
    end else if (|roll_t[wscr_pkg::ROWT_W-2:18]) begin
      roll_row = wscr_pkg::ROW_MAX;
    end else begin
      roll_row = roll_t[17:12];
    end
    if (sweep_t[wscr_pkg::ROWT_W-1]) begin
      sweep_row = wscr_pkg::ROW_MIN;
    end else if (|sweep_t[wscr_pkg::ROWT_W-2:26]) begin
      sweep_row = wscr_pkg::ROW_MAX;
    end else begin
      sweep_row = sweep_t[25:20];
    end
  end

  always_comb begin
    if (seg_old < seg_new) begin
      seg_lo = seg_old;
      seg_hi = seg_new;
    end else begin
      seg_lo = seg_new;
      seg_hi = seg_old;
    end
    for (int k = 0; k < wscr_pkg::PIXELS_W; k++) begin
      seg_mask[k] = (wscr_pkg::ROW_W'(k) >= seg_lo) && (wscr_pkg::ROW_W'(k) <= seg_hi);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wscr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wscr_pkg::S_IDLE: begin
        if (feed_take && kind == wscr_pkg::KIND_SAMPLE) begin
          if (plot_mode == wscr_pkg::MODE_ROLLING) begin
            state_next = wscr_pkg::S_ROLL_MUL;
          end else if (!settling) begin
            state_next = wscr_pkg::S_BASE_MUL;
          end
        end
      end
      wscr_pkg::S_ROLL_MUL:  state_next = wscr_pkg::S_ROLL_ROW;
      wscr_pkg::S_ROLL_ROW:  state_next = wscr_pkg::S_DRAW;
      wscr_pkg::S_BASE_MUL:  state_next = wscr_pkg::S_BASE_UPD;
      wscr_pkg::S_BASE_UPD:  state_next = wscr_pkg::S_TRIG;
      wscr_pkg::S_TRIG:      state_next = proceed ? wscr_pkg::S_SWEEP_MUL : wscr_pkg::S_IDLE;
      wscr_pkg::S_SWEEP_MUL: state_next = wscr_pkg::S_SWEEP_ROW;
      wscr_pkg::S_SWEEP_ROW: state_next = wscr_pkg::S_DRAW;
      wscr_pkg::S_DRAW:      state_next = wscr_pkg::S_EMIT0;
      wscr_pkg::S_EMIT0:     if (!draw_stall) state_next = wscr_pkg::S_EMIT1;
      wscr_pkg::S_EMIT1:     if (!draw_stall) state_next = wscr_pkg::S_EMIT2;
      wscr_pkg::S_EMIT2:     if (!draw_stall) state_next = wscr_pkg::S_IDLE;
      default:               state_next = wscr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    feed_stall = 1'b1;
    draw_valid = 1'b0;
    last       = 1'b0;
    mul_a      = base_diff;
    mul_b      = $signed({1'b0, smoothing_weight});
    case (state)
      wscr_pkg::S_IDLE: feed_stall = 1'b0;
      wscr_pkg::S_ROLL_MUL: begin
        mul_a = $signed({{(wscr_pkg::DIFF_W-wscr_pkg::SAMPLE_W){sample_reg[wscr_pkg::SAMPLE_W-1]}},
                         sample_reg});
        mul_b = $signed({5'b0, rolling_gain});
      end
      wscr_pkg::S_SWEEP_MUL: begin
        mul_a = n_reg;
        mul_b = $signed({5'b0, sweep_gain});
      end
      wscr_pkg::S_EMIT0, wscr_pkg::S_EMIT1: draw_valid = 1'b1;
      wscr_pkg::S_EMIT2: begin
        draw_valid = 1'b1;
        last       = 1'b1;
      end
      default: ;
    endcase
  end

  // Block state: reset to its documented values.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pointer   <= '0;
      rolling_last_row <= wscr_pkg::ROLLING_ROW_INIT;
      sweep_last_row   <= wscr_pkg::SWEEP_ROW_INIT;
      baseline         <= '0;
      previous_sample  <= '0;
      awaiting_trigger <= 1'b0;
      settle_counter   <= '0;
    end else begin
      case (state)
        wscr_pkg::S_IDLE: begin
          if (feed_take) begin
            if (kind == wscr_pkg::KIND_RESTART) begin
              column_pointer   <= '0;
              sweep_last_row   <= wscr_pkg::SWEEP_ROW_INIT;
              awaiting_trigger <= 1'b1;
              settle_counter   <= '0;
            end else if (plot_mode == wscr_pkg::MODE_SWEEP && settling) begin
              settle_counter <= settle_counter + 8'd1;
              baseline       <= $signed({sample, 8'b0});
            end
          end
        end
        wscr_pkg::S_ROLL_ROW: rolling_last_row <= roll_row;
        wscr_pkg::S_BASE_UPD: begin
          // The true sum always fits the accumulator, so wrapping is exact.
          baseline         <= baseline + prod_shift[wscr_pkg::BASE_W-1:0];
          awaiting_trigger <= awaiting_trigger || (column_pointer == '0);
        end
        wscr_pkg::S_TRIG: begin
          if (proceed) begin
            awaiting_trigger <= 1'b0;
          end else begin
            previous_sample <= sample_reg;
          end
        end
        wscr_pkg::S_SWEEP_ROW: begin
          sweep_last_row  <= sweep_row;
          previous_sample <= sample_reg;
        end
        wscr_pkg::S_DRAW: column_pointer <= ptr_inc(column_pointer);
        default: ;
      endcase
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    case (state)
      wscr_pkg::S_IDLE: if (feed_take) sample_reg <= sample;
      wscr_pkg::S_ROLL_MUL, wscr_pkg::S_BASE_MUL, wscr_pkg::S_SWEEP_MUL: prod <= prod_next;
      wscr_pkg::S_ROLL_ROW: begin
        seg_old   <= rolling_last_row;
        seg_new   <= roll_row;
        whole_reg <= 1'b0;
      end
      wscr_pkg::S_TRIG: n_reg <= base_diff;
      wscr_pkg::S_SWEEP_ROW: begin
        seg_old   <= sweep_last_row;
        seg_new   <= sweep_row;
        whole_reg <= 1'b1;
      end
      wscr_pkg::S_DRAW: begin
        pixels_reg <= seg_mask;
        col_reg    <= column_pointer;
      end
      // The column pointer has already advanced, so the blank columns are the
      // two that follow it.
      wscr_pkg::S_EMIT0: begin
        if (!draw_stall) begin
          pixels_reg <= '0;
          col_reg    <= ptr_inc(column_pointer);
        end
      end
      wscr_pkg::S_EMIT1: if (!draw_stall) col_reg <= ptr_inc(col_reg);
      default: ;
    endcase
  end

  assign column       = wscr_pkg::COLUMN_W'(col_reg);
  assign pixels       = pixels_reg;
  assign whole_column = whole_reg;

endmodule
